// File: sv/id_allocator_with_free_stack_top_defines.svh
// ----------------------------------------------------------------------------
// id_allocator_with_free_stack_top_defines
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_WITH_FREE_STACK_TOP_DEFINES_SVH
`define ID_ALLOCATOR_WITH_FREE_STACK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
// trig in one cycle implies cond in the next
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sequence violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

// File: sv/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Types and constants shared by the id allocator controller and datapath.
// ----------------------------------------------------------------------------
package ida_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int MAX_BATCH_DEF = 16;
    localparam int MIN_SPAN_DEF  = 2;

    localparam int ID_W  = 10;   // id, start_index, item_id, next_start
    localparam int CNT_W = 5;    // max_count, found_count

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_QUERY   = 2'd2,
        KIND_SCAN    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_CHECK,
        ST_MOD,
        ST_SCAN_TEST,
        ST_SCAN_CHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic alloc_fresh;
        logic alloc_fail;
        logic stack_rd;
        logic pop_commit;
        logic valid_rd;
        logic check_commit;
        logic scan_init;
        logic mod_step;
        logic scan_rd;
        logic scan_step;
        logic scan_final;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  stack_empty;
        logic  hw_full;
        logic  mod_last;
        logic  scan_more;
        logic  hit;
        logic  res_last;
    } status_t;

    typedef struct packed {
        logic             ok;
        logic [ID_W-1:0]  item_id;
        logic             entry_found;
        logic [ID_W-1:0]  next_start;
        logic [CNT_W-1:0] found_count;
        logic             last;
    } res_t;

endpackage

// File: sv/ida_ctrl.sv
// ----------------------------------------------------------------------------
// ida_ctrl
// Sequencer for the id allocator: accepts a request, steps the datapath
// through it and holds each result until the receiver takes it.
// ----------------------------------------------------------------------------
`include "id_allocator_with_free_stack_top_defines.svh"

module ida_ctrl
    import ida_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_fire;

    assign out_fire = out_valid & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.kind)
                    KIND_ALLOC:
                    begin
                        // reuse a freed id before touching the high-water mark
                        priority if (!status.stack_empty)
                        begin
                            cmd.stack_rd = 1'b1;
                            state_next   = ST_POP;
                        end
                        else if (!status.hw_full)
                        begin
                            cmd.alloc_fresh = 1'b1;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            cmd.alloc_fail = 1'b1;
                            state_next     = ST_OUT;
                        end
                    end
                    KIND_RELEASE, KIND_QUERY:
                    begin
                        cmd.valid_rd = 1'b1;
                        state_next   = ST_CHECK;
                    end
                    KIND_SCAN:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_MOD;
                    end
                endcase
            end
            ST_POP:
            begin
                cmd.pop_commit = 1'b1;
                state_next     = ST_OUT;
            end
            ST_CHECK:
            begin
                cmd.check_commit = 1'b1;
                state_next       = ST_OUT;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                    state_next = ST_SCAN_TEST;
            end
            ST_SCAN_TEST:
            begin
                if (status.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
                else
                begin
                    cmd.scan_final = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_SCAN_CHK:
            begin
                cmd.scan_step = 1'b1;
                state_next    = status.hit ? ST_OUT : ST_SCAN_TEST;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                // hold the result until taken; a scan hit resumes the walk
                if (out_ready)
                    state_next = status.res_last ? ST_IDLE : ST_SCAN_TEST;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_last_returns_idle, clk, rst_n, out_fire && status.res_last, state_reg == ST_IDLE)

endmodule

// File: sv/ida_datapath.sv
// ----------------------------------------------------------------------------
// ida_datapath
// Valid-bit memory, freed-id stack, high-water mark, span and scan walker.
// ----------------------------------------------------------------------------
`include "id_allocator_with_free_stack_top_defines.svh"

module ida_datapath
    import ida_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF,
    parameter int MIN_SPAN  = MIN_SPAN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          status,
    input  kind_t            kind,
    input  logic [ID_W-1:0]  id,
    input  logic [ID_W-1:0]  start_index,
    input  logic [CNT_W-1:0] max_count,
    output res_t             res
);

    localparam int IW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int BW       = $clog2(MAX_BATCH + 1);
    localparam int SW       = $clog2(ID_W);
    localparam int SPAN_RST = (MIN_SPAN > CAPACITY) ? CAPACITY : MIN_SPAN;
    localparam logic [SW-1:0] TOP_BIT = SW'(ID_W - 1);

    // storage
    logic          valid_mem [CAPACITY];
    logic [IW-1:0] stack_mem [CAPACITY];
    logic          valid_q;
    logic [IW-1:0] stack_q;

    // memory port controls
    logic          v_we;
    logic [IW-1:0] v_waddr;
    logic          v_wdata;
    logic          v_re;
    logic [IW-1:0] v_raddr;
    logic          s_we;
    logic [IW-1:0] s_waddr;
    logic [IW-1:0] s_wdata;
    logic          s_re;
    logic [IW-1:0] s_raddr;

    // control state
    logic [CW-1:0]   sc_reg, sc_next;
    logic [CW-1:0]   hw_reg, hw_next;
    logic [CW-1:0]   span_reg, span_next;
    logic [BW-1:0]   found_reg, found_next;
    logic [BW-1:0]   limit_reg, limit_next;
    logic [CW-1:0]   walked_reg, walked_next;

    // request and work registers
    kind_t           kind_reg, kind_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] start_reg, start_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [CW:0]     rem_reg, rem_next;
    logic [SW-1:0]   step_reg, step_next;
    res_t            res_reg, res_next;

    // combinational helpers
    logic            id_ok;
    logic            hit;
    logic [CW:0]     span_dbl;
    logic [CW:0]     rem_sh;
    logic [CW-1:0]   pos_inc;

    assign span_dbl = {span_reg, 1'b0};
    assign rem_sh   = {rem_reg[CW-1:0], start_reg[TOP_BIT - step_reg]};
    assign pos_inc  = CW'(pos_reg) + CW'(1);
    // ids at or above the high-water mark were never written: read as clear
    assign id_ok    = valid_q && (32'(id_reg) < 32'(span_reg))
                      && (32'(id_reg) < 32'(hw_reg));
    assign hit      = valid_q && (CW'(pos_reg) < hw_reg);

    always_comb
    begin
        status.kind        = kind_reg;
        status.stack_empty = (sc_reg == '0);
        status.hw_full     = (hw_reg == CW'(CAPACITY));
        status.mod_last    = (step_reg == TOP_BIT);
        status.scan_more   = (found_reg < limit_reg) && (walked_reg < span_reg);
        status.hit         = hit;
        status.res_last    = res_reg.last;
    end

    assign res = res_reg;

    always_comb
    begin
        sc_next     = sc_reg;
        hw_next     = hw_reg;
        span_next   = span_reg;
        found_next  = found_reg;
        limit_next  = limit_reg;
        walked_next = walked_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        res_next    = res_reg;
        v_we        = 1'b0;
        v_waddr     = IW'(id_reg);
        v_wdata     = 1'b0;
        v_re        = 1'b0;
        v_raddr     = IW'(id_reg);
        s_we        = 1'b0;
        s_waddr     = IW'(sc_reg);
        s_wdata     = IW'(id_reg);
        s_re        = 1'b0;
        s_raddr     = IW'(sc_reg - CW'(1));

        if (cmd.load)
        begin
            kind_next  = kind;
            id_next    = id;
            start_next = start_index;
            limit_next = (32'(max_count) > MAX_BATCH) ? BW'(MAX_BATCH) : BW'(max_count);
            // keep the found count within the new limit
            found_next = '0;
        end

        if (cmd.alloc_fresh)
        begin
            v_we    = 1'b1;
            v_waddr = IW'(hw_reg);
            v_wdata = 1'b1;
            hw_next = hw_reg + CW'(1);
            if (hw_reg >= span_reg)
                span_next = (span_dbl > (CW+1)'(CAPACITY)) ? CW'(CAPACITY) : CW'(span_dbl);
            res_next         = '0;
            res_next.ok      = 1'b1;
            res_next.item_id = ID_W'(hw_reg);
            res_next.last    = 1'b1;
        end

        if (cmd.alloc_fail)
        begin
            res_next      = '0;
            res_next.last = 1'b1;
        end

        if (cmd.stack_rd)
            s_re = 1'b1;

        if (cmd.pop_commit)
        begin
            v_we             = 1'b1;
            v_waddr          = stack_q;
            v_wdata          = 1'b1;
            sc_next          = sc_reg - CW'(1);
            res_next         = '0;
            res_next.ok      = 1'b1;
            res_next.item_id = ID_W'(stack_q);
            res_next.last    = 1'b1;
        end

        if (cmd.valid_rd)
            v_re = 1'b1;

        if (cmd.check_commit)
        begin
            res_next      = '0;
            res_next.ok   = id_ok;
            res_next.last = 1'b1;
            if (kind_reg == KIND_RELEASE && id_ok)
            begin
                // clear the bit and push the id
                v_we    = 1'b1;
                v_wdata = 1'b0;
                if (sc_reg < CW'(CAPACITY))
                begin
                    s_we    = 1'b1;
                    sc_next = sc_reg + CW'(1);
                end
            end
        end

        if (cmd.scan_init)
        begin
            rem_next    = '0;
            step_next   = '0;
            found_next  = '0;
            walked_next = '0;
        end

        if (cmd.mod_step)
        begin
            // restoring remainder of start_index by span, one bit per cycle
            rem_next  = (rem_sh >= {1'b0, span_reg}) ? rem_sh - {1'b0, span_reg} : rem_sh;
            step_next = step_reg + SW'(1);
            if (step_reg == TOP_BIT)
                pos_next = IW'(rem_next);
        end

        if (cmd.scan_rd)
        begin
            v_re    = 1'b1;
            v_raddr = pos_reg;
        end

        if (cmd.scan_step)
        begin
            if (hit)
            begin
                res_next             = '0;
                res_next.item_id     = ID_W'(pos_reg);
                res_next.entry_found = 1'b1;
                found_next           = found_reg + BW'(1);
            end
            pos_next    = (pos_inc == span_reg) ? '0 : IW'(pos_inc);
            walked_next = walked_reg + CW'(1);
        end

        if (cmd.scan_final)
        begin
            res_next             = '0;
            res_next.next_start  = ID_W'(pos_reg);
            res_next.found_count = CNT_W'(found_reg);
            res_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg     <= '0;
            hw_reg     <= '0;
            span_reg   <= CW'(SPAN_RST);
            found_reg  <= '0;
            limit_reg  <= '0;
            walked_reg <= '0;
        end
        else
        begin
            sc_reg     <= sc_next;
            hw_reg     <= hw_next;
            span_reg   <= span_next;
            found_reg  <= found_next;
            limit_reg  <= limit_next;
            walked_reg <= walked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        start_reg <= start_next;
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            valid_mem[v_waddr] <= v_wdata;
        if (v_re)
            valid_q <= valid_mem[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_waddr] <= s_wdata;
        if (s_re)
            stack_q <= stack_mem[s_raddr];
    end

    // the stack never holds more ids than the high-water mark
    `ASSERT_ALWAYS(a_stack_le_hw, clk, rst_n, sc_reg <= hw_reg)
    `ASSERT_ALWAYS(a_hw_le_span, clk, rst_n, hw_reg <= span_reg)
    `ASSERT_ALWAYS(a_found_le_limit, clk, rst_n, found_reg <= limit_reg)

endmodule

// File: sv/id_allocator_with_free_stack_top.sv
// ----------------------------------------------------------------------------
// id_allocator_with_free_stack_top
// Id allocator with a LIFO stack of freed ids and a round-robin batch scan.
// ----------------------------------------------------------------------------
// Usage:
//   One request transaction on s_axis (tuser = kind) gives one or more result
//   transactions on m_axis; m_axis_tlast marks the final result of a request.
//   Allocate pops the most recently freed id, else takes the fresh id at the
//   high-water mark; release and query check span bounds, then the valid bit.
//   A batch scan emits one result per valid id found (tuser = entry_found),
//   then a last result with next_start and found_count.
// Timing:
//   One request at a time; s_axis_tready is high only between requests.
//   A fresh allocate needs no memory read; allocate from the stack, release
//   and query wait on the registered read of the valid-bit or stack
//   memory. A scan runs a 10-step remainder of start_index by the span,
//   then one valid-bit read per examined entry.
// Reset and stall:
//   Reset empties the stack and sets the high-water mark to zero and the span
//   to MIN_SPAN; no clearing pass, ids at or above the mark read as not valid.
//   A stalled receiver holds the current result and pauses the scan.
// ----------------------------------------------------------------------------
module id_allocator_with_free_stack_top
    import ida_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF,
    parameter int MIN_SPAN  = MIN_SPAN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // id[9:0], start_index[19:10], max_count[24:20]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // ok[0], item_id[10:1], next_start[20:11],
                                        // found_count[25:21]
    output logic [0:0]  m_axis_tuser,   // entry_found[0]
    output logic        m_axis_tlast
);

    cmd_t    cmd;
    status_t status;
    res_t    res;

    ida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ida_datapath #(
        .CAPACITY  (CAPACITY),
        .MAX_BATCH (MAX_BATCH),
        .MIN_SPAN  (MIN_SPAN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind_t'(s_axis_tuser)),
        .id          (s_axis_tdata[9:0]),
        .start_index (s_axis_tdata[19:10]),
        .max_count   (s_axis_tdata[24:20]),
        .res         (res)
    );

    assign m_axis_tdata = {6'b0, res.found_count, res.next_start, res.item_id, res.ok};
    assign m_axis_tuser = res.entry_found;
    assign m_axis_tlast = res.last;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the id allocator: a queue-fed stream driver, a
// result monitor with its own stall pattern, and an in-bench model of the
// free-id stack, valid bits, high-water mark and round-robin batch scan.
// ----------------------------------------------------------------------------
module tb;
    import ida_pkg::*;

    localparam int IDS        = CAPACITY_DEF;
    localparam int WATCHDOG   = 10000;
    localparam int RANDOM_REQ = 360;
    localparam int FILL_REQ   = 48;

    typedef struct {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    start_index;
        logic [CNT_W-1:0]   max_count;
        bit                 drain;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = KIND_ALLOC;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    request_t pending_q[$];
    res_t     expected_q[$];
    request_t cur_req;

    // model state
    bit              id_valid [IDS];
    logic [ID_W-1:0] free_ids [IDS];
    int unsigned     free_top;
    int unsigned     fresh_mark;
    int unsigned     span_now;

    int unsigned inputs_accepted;
    int unsigned mismatches;
    int unsigned n_alloc, n_alloc_fail, n_release, n_release_refused, n_query;
    int unsigned n_scan, n_scan_hits;

    int burst_left, gap_left;
    int idle_cycles;
    int hold_left, next_hold_at, pat_phase;
    logic [15:0] ready_pat;

    id_allocator_with_free_stack_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic res_t make_result(bit ok, int unsigned item, bit found,
                                         int unsigned next, int unsigned count, bit last);
        res_t r;
        r.ok          = ok;
        r.item_id     = item[ID_W-1:0];
        r.entry_found = found;
        r.next_start  = next[ID_W-1:0];
        r.found_count = count[CNT_W-1:0];
        r.last        = last;
        return r;
    endfunction

    function automatic request_t make_req(kind_t k, int unsigned id, int unsigned st,
                                          int unsigned mc, bit drain);
        request_t r;
        r.kind        = k;
        r.id          = id[ID_W-1:0];
        r.start_index = st[ID_W-1:0];
        r.max_count   = mc[CNT_W-1:0];
        r.drain       = drain;
        return r;
    endfunction

    // Work out the results of one accepted request and update the model.
    task automatic predict_request(request_t r);
        int unsigned got, limit, pos, walked, found;
        case (r.kind)
            KIND_ALLOC:
            begin
                n_alloc++;
                if (free_top > 0) begin
                    free_top--;
                    got = free_ids[free_top];
                end
                else if (fresh_mark < IDS) begin
                    if (fresh_mark >= span_now)
                        span_now = (span_now * 2 > IDS) ? IDS : span_now * 2;
                    got = fresh_mark;
                    fresh_mark++;
                end
                else begin
                    n_alloc_fail++;
                    expected_q.push_back(make_result(0, 0, 0, 0, 0, 1));
                    return;
                end
                id_valid[got] = 1'b1;
                expected_q.push_back(make_result(1, got, 0, 0, 0, 1));
            end
            KIND_RELEASE:
            begin
                n_release++;
                // bounds first, then the valid bit
                if (r.id < span_now && id_valid[r.id]) begin
                    id_valid[r.id] = 1'b0;
                    free_ids[free_top] = r.id;
                    free_top++;
                    expected_q.push_back(make_result(1, 0, 0, 0, 0, 1));
                end
                else begin
                    n_release_refused++;
                    expected_q.push_back(make_result(0, 0, 0, 0, 0, 1));
                end
            end
            KIND_QUERY:
            begin
                n_query++;
                expected_q.push_back(make_result(r.id < span_now && id_valid[r.id],
                                                 0, 0, 0, 0, 1));
            end
            default:
            begin
                n_scan++;
                limit  = (r.max_count > MAX_BATCH_DEF) ? MAX_BATCH_DEF : r.max_count;
                pos    = r.start_index % span_now;
                walked = 0;
                found  = 0;
                while (found < limit && walked < span_now) begin
                    if (id_valid[pos]) begin
                        expected_q.push_back(make_result(0, pos, 1, 0, 0, 0));
                        found++;
                    end
                    pos = (pos + 1) % span_now;
                    walked++;
                end
                n_scan_hits += found;
                expected_q.push_back(make_result(0, 0, 0, pos, found, 1));
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < 40)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_result(res_t got);
        res_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.ok !== want.ok)
            report_mismatch("ok", got.ok, want.ok);
        if (got.item_id !== want.item_id)
            report_mismatch("item_id", got.item_id, want.item_id);
        if (got.entry_found !== want.entry_found)
            report_mismatch("entry_found", got.entry_found, want.entry_found);
        if (got.next_start !== want.next_start)
            report_mismatch("next_start", got.next_start, want.next_start);
        if (got.found_count !== want.found_count)
            report_mismatch("found_count", got.found_count, want.found_count);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    // request driver: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_ALLOC;
            burst_left = 4;
            gap_left   = 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(cur_req);
                inputs_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && expected_q.size() != 0)) begin
                    cur_req = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, cur_req.max_count, cur_req.start_index,
                                      cur_req.id};
                    s_axis_tuser  <= cur_req.kind;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own ready pattern and occasional long holds
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            ready_pat    = 16'hFFFF;
            pat_phase    = 0;
            hold_left    = 0;
            next_hold_at = 60;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(make_result(m_axis_tdata[0], m_axis_tdata[10:1], m_axis_tuser[0],
                                         m_axis_tdata[20:11], m_axis_tdata[25:21],
                                         m_axis_tlast));
            if (inputs_accepted >= next_hold_at) begin
                hold_left    = 250;
                next_hold_at = next_hold_at + 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= ready_pat[pat_phase];
                pat_phase++;
                if (pat_phase == 16) begin
                    pat_phase = 0;
                    case ($urandom_range(0, 2))
                        0:       ready_pat = 16'hFFFF;
                        1:       ready_pat = 16'($urandom);
                        default: ready_pat = 16'($urandom | $urandom);
                    endcase
                end
            end
        end
    end

    // watchdog: end the run after too many cycles without any transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired with %0d results outstanding", expected_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned allocs_made, live_hi, pick, sel, mc;
        kind_t k;

        free_top   = 0;
        fresh_mark = 0;
        span_now   = MIN_SPAN_DEF;
        idle_cycles = 0;

        // directed: empty state, span growth, refusals, LIFO reuse, scan limits
        pending_q.push_back(make_req(KIND_QUERY,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_SCAN,    0,    1023, 0,  0));
        pending_q.push_back(make_req(KIND_SCAN,    0,    0,    5,  0));
        pending_q.push_back(make_req(KIND_ALLOC,   1023, 1023, 31, 0));
        pending_q.push_back(make_req(KIND_ALLOC,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_ALLOC,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_RELEASE, 1023, 0,    0,  0));
        pending_q.push_back(make_req(KIND_RELEASE, 3,    0,    0,  0));
        pending_q.push_back(make_req(KIND_RELEASE, 1,    0,    0,  0));
        pending_q.push_back(make_req(KIND_RELEASE, 1,    0,    0,  0));
        pending_q.push_back(make_req(KIND_QUERY,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_QUERY,   1,    0,    0,  0));
        pending_q.push_back(make_req(KIND_QUERY,   1023, 1023, 31, 0));
        pending_q.push_back(make_req(KIND_ALLOC,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_SCAN,    0,    1023, 31, 0));
        pending_q.push_back(make_req(KIND_SCAN,    0,    2,    1,  0));
        pending_q.push_back(make_req(KIND_SCAN,    0,    513,  16, 1));
        pending_q.push_back(make_req(KIND_RELEASE, 0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_RELEASE, 2,    0,    0,  0));
        pending_q.push_back(make_req(KIND_ALLOC,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_ALLOC,   0,    0,    0,  0));
        pending_q.push_back(make_req(KIND_SCAN,    0,    0,    17, 0));

        // random mix, ids biased toward those likely handed out
        allocs_made = 5;
        for (int i = 0; i < RANDOM_REQ; i++) begin
            sel     = $urandom_range(0, 99);
            live_hi = (allocs_made > 1023) ? 1023 : allocs_made;
            pick    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, live_hi)
                                                 : $urandom_range(0, 1023);
            if (sel < 35) begin
                k = KIND_ALLOC;
                allocs_made++;
            end
            else if (sel < 60)
                k = KIND_RELEASE;
            else if (sel < 75)
                k = KIND_QUERY;
            else
                k = KIND_SCAN;
            mc = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            pending_q.push_back(make_req(k, pick, $urandom_range(0, 1023), mc,
                                         $urandom_range(0, 39) == 0));
        end

        // run of allocations: empty the stack, then take fresh ids and grow the span
        for (int i = 0; i < FILL_REQ; i++)
            pending_q.push_back(make_req(KIND_ALLOC, $urandom_range(0, 1023),
                                         $urandom_range(0, 1023), $urandom_range(0, 31),
                                         i == 0));

        // mixed tail
        for (int i = 0; i < 20; i++) begin
            case ($urandom_range(0, 3))
                0:       k = KIND_ALLOC;
                1:       k = KIND_RELEASE;
                2:       k = KIND_QUERY;
                default: k = KIND_SCAN;
            endcase
            pending_q.push_back(make_req(k, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                         $urandom_range(0, 31), i == 0));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d requests: %0d allocs (%0d refused), %0d releases (%0d refused), %0d queries",
                 inputs_accepted, n_alloc, n_alloc_fail, n_release, n_release_refused, n_query);
        $display("%0d batch scans returned %0d ids; span reached %0d; %0d mismatches",
                 n_scan, n_scan_hits, span_now, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
